// ----- rtl/btsd_pkg.sv -----
package btsd_pkg;

  typedef enum logic [1:0] {
    KIND_OPCODE  = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_CALL    = 2'd2
  } token_kind_e;

  typedef enum logic [1:0] {
    FMT_FIXED2 = 2'd0,
    FMT_VARINT = 2'd1,
    FMT_FIXED3 = 2'd2
  } token_format_e;

  localparam logic [7:0] EscLiteral = 8'h7D;
  localparam int unsigned ValueOutBits = 32;

  typedef struct packed {
    logic                    emit;
    token_kind_e             kind;
    logic [ValueOutBits-1:0] value;
  } result_t;

endpackage

// ----- rtl/byte_token_stream_decoder.sv -----
// path: the last code byte of a token is held in the input register, decoded
// combinationally and captured in the result register, from which it can transfer
// throughput: one code byte per cycle while the result register is empty or
// m_axis_tready is high; a stalled result holds the byte in the input register
// reset: asynchronous active low; clears the decode state, the accumulator and
// both valid flags, and sets the format to varint
module byte_token_stream_decoder #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,    // token_format
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // code_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // token_value
  output logic [1:0]  m_axis_tuser    // token_kind
);

  logic [1:0]        token_format_q;
  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_value_q;
  logic [1:0]        out_kind_q;
  logic              step;
  btsd_pkg::result_t result;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  btsd_decode #(
    .VALUE_BITS(VALUE_BITS)
  ) u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .code_byte_i   (in_byte_q),
    .token_format_i(token_format_q),
    .result_o      (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (step) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = result.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_format_q <= btsd_pkg::FMT_VARINT;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        token_format_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step && result.emit) begin
      out_value_q <= result.value;
      out_kind_q  <= result.kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

// ----- rtl/btsd_decode.sv -----
module btsd_decode #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           code_byte_i,
  input  logic [1:0]           token_format_i,
  output btsd_pkg::result_t    result_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LIT,
    PH_F2_LAST,
    PH_F3_MID,
    PH_F3_LAST,
    PH_VARINT
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [VALUE_BITS-1:0] acc_shift8, acc_shift7, acc_lead, acc_call;
  logic [btsd_pkg::ValueOutBits-1:0] acc_low;

  assign acc_shift8 = {acc_q[VALUE_BITS-9:0], code_byte_i};
  assign acc_shift7 = {acc_q[VALUE_BITS-8:0], code_byte_i[6:0]};
  assign acc_lead   = {{(VALUE_BITS-7){1'b0}}, code_byte_i[6:0]};
  assign acc_call   = (phase_q == PH_VARINT) ? acc_shift7 : acc_shift8;

  if (VALUE_BITS >= btsd_pkg::ValueOutBits) begin : g_wide
    assign acc_low = acc_call[btsd_pkg::ValueOutBits-1:0];
  end else begin : g_narrow
    assign acc_low = {{(btsd_pkg::ValueOutBits-VALUE_BITS){1'b0}}, acc_call};
  end

  always_comb begin
    phase_d         = phase_q;
    acc_d           = acc_q;
    result_o.emit   = 1'b0;
    result_o.kind   = btsd_pkg::KIND_OPCODE;
    result_o.value  = {{(btsd_pkg::ValueOutBits-8){1'b0}}, code_byte_i};
    case (phase_q)
      PH_LIT: begin
        phase_d       = PH_IDLE;
        result_o.emit = 1'b1;
        result_o.kind = btsd_pkg::KIND_LITERAL;
      end
      PH_F2_LAST, PH_F3_LAST: begin
        phase_d        = PH_IDLE;
        acc_d          = acc_shift8;
        result_o.emit  = 1'b1;
        result_o.kind  = btsd_pkg::KIND_CALL;
        result_o.value = acc_low;
      end
      PH_F3_MID: begin
        phase_d = PH_F3_LAST;
        acc_d   = acc_shift8;
      end
      PH_VARINT: begin
        acc_d = acc_shift7;
        if (!code_byte_i[7]) begin
          phase_d        = PH_IDLE;
          result_o.emit  = 1'b1;
          result_o.kind  = btsd_pkg::KIND_CALL;
          result_o.value = acc_low;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (!code_byte_i[7]) begin
          if (code_byte_i == btsd_pkg::EscLiteral) begin
            phase_d = PH_LIT;
          end else begin
            result_o.emit = 1'b1;
          end
        end else begin
          acc_d = acc_lead;
          case (token_format_i)
            btsd_pkg::FMT_VARINT: phase_d = PH_VARINT;
            btsd_pkg::FMT_FIXED3: phase_d = PH_F3_MID;
            default:              phase_d = PH_F2_LAST;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

endmodule
